### hdl/lpcm_pkg.sv
package lpcm_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_BOTTOM = 2'd0,
		CFG_RANGE_TOP    = 2'd1,
		CFG_BLEND_ENABLE = 2'd2,
		CFG_COLOR_COUNT  = 2'd3
	} cfg_reg_t;

	// How the palette entry for a sample is chosen.
	typedef enum logic [2:0] {
		PICK_BAD_SPAN = 3'd0,
		PICK_FIRST    = 3'd1,
		PICK_LAST     = 3'd2,
		PICK_BAND     = 3'd3,
		PICK_BLEND    = 3'd4
	} pick_t;

	// Width of the divider remainder and of the value span.
	localparam int SPAN_W = 32;

	// Input word kinds carried on tuser.
	localparam logic KIND_MAP   = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

endpackage

### hdl/lpcm_ram.sv
module lpcm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hdl/lpcm_div.sv
module lpcm_div #(
	parameter int QB = 12,
	parameter int LW = 4,
	parameter int SW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [lpcm_pkg::SPAN_W-1:0]   in_rem,
	input  logic [LW-1:0]                 in_low,
	input  logic [lpcm_pkg::SPAN_W-1:0]   in_span,
	input  logic [SW-1:0]                 in_side,
	output logic                          out_valid,
	output logic [QB-1:0]                 out_q,
	output logic [SW-1:0]                 out_side
);
	import lpcm_pkg::*;

	// Stage 0 is the input; stage j+1 holds the state after quotient bit j.
	logic              valid_s [QB+1];
	logic [SPAN_W-1:0] rem_s   [QB+1];
	logic [SPAN_W-1:0] span_s  [QB+1];
	logic [QB-1:0]     bits_s  [QB+1];
	logic [QB-1:0]     quo_s   [QB+1];
	logic [SW-1:0]     side_s  [QB+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = in_rem;
	assign span_s[0]  = in_span;
	assign bits_s[0]  = {in_low, {(QB-LW){1'b0}}};
	assign quo_s[0]   = '0;
	assign side_s[0]  = in_side;

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic [SPAN_W:0] trial;
		logic [SPAN_W:0] diff;
		logic            ge;

		// Restoring step: bring down one dividend bit, subtract if it fits.
		always_comb begin
			trial = {rem_s[j], bits_s[j][QB-1]};
			ge    = trial >= {1'b0, span_s[j]};
			diff  = trial - {1'b0, span_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
				span_s[j+1] <= span_s[j];
				bits_s[j+1] <= bits_s[j] << 1;
				quo_s[j+1]  <= {quo_s[j][QB-2:0], ge};
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = valid_s[QB];
	assign out_q     = quo_s[QB];
	assign out_side  = side_s[QB];
endmodule

### hdl/level_palette_color_map.sv
// Pseudocolor palette lookup. A word with tuser 1 writes one 24-bit palette
// entry and gives no output; a word with tuser 0 maps a signed Q16.16 sample
// to an RGB color, either as a band or blended between neighboring entries.
// The block takes one word per clock cycle unless the master side stalls.
// Most of the pipeline is the bit-per-stage divider that turns the scaled
// offset into entry index and blend fraction. The palette is cleared at
// reset by per-entry valid bits, so no clearing pass is needed.
module level_palette_color_map #(
	parameter int MAX_COLORS    = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [lpcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	// Slave side.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// sample_value[31:0], entry_index[35:32], entry_red[43:36],
	// entry_green[51:44], entry_blue[59:52], zero fill
	input  logic [63:0]                    s_tdata,
	// mode
	input  logic                           s_tuser,
	// Master side.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], band_index[27:24], zero fill
	output logic [31:0]                    m_tdata,
	// span_invalid
	output logic                           m_tuser
);
	import lpcm_pkg::*;

	localparam int AW   = (MAX_COLORS > 2) ? $clog2(MAX_COLORS) : 1;
	localparam int NW   = $clog2(MAX_COLORS + 1);
	localparam int QB   = AW + FRACTION_BITS;
	localparam int PW   = 32 + NW;
	localparam int SW   = 1 + 3 + AW + 24;
	localparam int SUMW = 8 + FRACTION_BITS;
	localparam int BW   = (AW > 4) ? AW : 4;

	// Configuration registers.
	logic signed [31:0] bottom_q;
	logic signed [31:0] top_q;
	logic               blend_q;
	logic [4:0]         count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= '0;
			top_q    <= '0;
			blend_q  <= 1'b0;
			count_q  <= 5'd2;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RANGE_BOTTOM: bottom_q <= cfg_data;
				CFG_RANGE_TOP:    top_q    <= cfg_data;
				CFG_BLEND_ENABLE: blend_q  <= cfg_data[0];
				CFG_COLOR_COUNT:  count_q  <= cfg_data[4:0];
			endcase
		end
	end

	// Entry count clamped to 2..MAX_COLORS.
	logic [NW-1:0] n_cnt;
	logic [AW-1:0] last_addr;
	always_comb begin
		if (count_q < 5'd2) begin
			n_cnt = NW'(2);
		end else if (32'(count_q) > MAX_COLORS) begin
			n_cnt = NW'(MAX_COLORS);
		end else begin
			n_cnt = NW'(count_q);
		end
		last_addr = AW'(n_cnt - NW'(1));
	end

	// The whole pipeline moves when the output register is free or drained.
	logic advance;
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	// Fold an entry index into the store size.
	function automatic logic [AW-1:0] fold_index(input logic [3:0] ei);
		logic [8:0] t;
		t = {5'd0, ei};
		for (int k = 0; k < 8; k++) begin
			if (32'(t) >= MAX_COLORS) begin
				t = t - 9'(MAX_COLORS);
			end
		end
		return AW'(t);
	endfunction

	// Stage 1: input register.
	logic               valid_s1;
	logic               wr_s1;
	logic signed [31:0] val_s1;
	logic [AW-1:0]      ei_s1;
	logic [23:0]        rgb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_s1  <= s_tuser == KIND_WRITE;
			val_s1 <= s_tdata[31:0];
			ei_s1  <= fold_index(s_tdata[35:32]);
			rgb_s1 <= {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52]};
		end
	end

	// Offset, span and choice of mapping.
	logic signed [32:0] d_full;
	logic signed [32:0] span_full;
	logic               span_bad;
	logic               in_blend;
	pick_t              pick_c;
	always_comb begin
		d_full    = {val_s1[31], val_s1} - {bottom_q[31], bottom_q};
		span_full = {top_q[31], top_q} - {bottom_q[31], bottom_q};
		span_bad  = top_q <= bottom_q;
		in_blend  = blend_q && (val_s1 > bottom_q) && (val_s1 < top_q);
		if (span_bad) begin
			pick_c = PICK_BAD_SPAN;
		end else if (in_blend) begin
			pick_c = PICK_BLEND;
		end else if (d_full[32]) begin
			pick_c = PICK_FIRST;
		end else if (d_full >= span_full) begin
			pick_c = PICK_LAST;
		end else begin
			pick_c = PICK_BAND;
		end
	end

	// Stage 2: offset and multiplier ready.
	logic              valid_s2;
	logic [31:0]       d_s2;
	logic [31:0]       span_s2;
	logic [NW-1:0]     m_s2;
	logic [SW-1:0]     side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_s2    <= d_full[31:0];
			span_s2 <= span_full[31:0];
			m_s2    <= in_blend ? n_cnt - NW'(1) : n_cnt;
			side_s2 <= {wr_s1, pick_c, ei_s1, rgb_s1};
		end
	end

	// Stage 3: scaled offset.
	logic          valid_s3;
	logic [PW-1:0] pos_s3;
	logic [31:0]   span_s3;
	logic [SW-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_s3  <= PW'(d_s2) * PW'(m_s2);
			span_s3 <= span_s2;
			side_s3 <= side_s2;
		end
	end

	// Divider: quotient holds the entry index above the fraction bits.
	logic          valid_s4;
	logic [QB-1:0] quo_s4;
	logic [SW-1:0] side_s4;

	lpcm_div #(
		.QB (QB),
		.LW (AW),
		.SW (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s3),
		.in_rem    (pos_s3[AW +: 32]),
		.in_low    (pos_s3[AW-1:0]),
		.in_span   (span_s3),
		.in_side   (side_s3),
		.out_valid (valid_s4),
		.out_q     (quo_s4),
		.out_side  (side_s4)
	);

	// Unpack the sideband and choose the addresses.
	logic          wr_s4;
	pick_t         pick_s4;
	logic [AW-1:0] ei_s4;
	logic [23:0]   rgb_s4;
	logic [AW-1:0] idx_s4;
	logic [AW-1:0] lo_addr;
	logic [AW-1:0] hi_addr;
	logic          wr_en;
	always_comb begin
		wr_s4   = side_s4[SW-1];
		pick_s4 = pick_t'(side_s4[SW-2 -: 3]);
		ei_s4   = side_s4[24 +: AW];
		rgb_s4  = side_s4[23:0];
		idx_s4  = quo_s4[QB-1 -: AW];
		unique case (pick_s4)
			PICK_LAST:              lo_addr = last_addr;
			PICK_BAND, PICK_BLEND:  lo_addr = idx_s4;
			default:                lo_addr = '0;
		endcase
		hi_addr = (pick_s4 == PICK_BLEND) ? lo_addr + AW'(1) : lo_addr;
		wr_en   = advance && valid_s4 && wr_s4;
	end

	// Palette valid bits: an entry never written reads as zero.
	logic [MAX_COLORS-1:0] pal_vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (wr_en) begin
			pal_vld_q[ei_s4] <= 1'b1;
		end
	end

	logic [23:0] lo_rd;
	logic [23:0] hi_rd;

	lpcm_ram #(.WIDTH(24), .DEPTH(MAX_COLORS)) u_ram_lo (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ei_s4),
		.wdata (rgb_s4),
		.re    (advance),
		.raddr (lo_addr),
		.rdata (lo_rd)
	);

	lpcm_ram #(.WIDTH(24), .DEPTH(MAX_COLORS)) u_ram_hi (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ei_s4),
		.wdata (rgb_s4),
		.re    (advance),
		.raddr (hi_addr),
		.rdata (hi_rd)
	);

	// Stage 5: palette read.
	logic                     valid_s5;
	logic                     wr_s5;
	pick_t                    pick_s5;
	logic [AW-1:0]            band_s5;
	logic [FRACTION_BITS-1:0] frac_s5;
	logic                     lo_ok_s5;
	logic                     hi_ok_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_s5    <= wr_s4;
			pick_s5  <= pick_s4;
			band_s5  <= lo_addr;
			frac_s5  <= quo_s4[FRACTION_BITS-1:0];
			lo_ok_s5 <= pal_vld_q[lo_addr];
			hi_ok_s5 <= pal_vld_q[hi_addr];
		end
	end

	// Per-channel blend; a plain entry is placed above the fraction bits.
	logic [23:0]              lo_c;
	logic [23:0]              hi_c;
	logic [FRACTION_BITS:0]   w_lo;
	logic [FRACTION_BITS:0]   w_hi;
	logic [SUMW-1:0]          sum_c [3];
	always_comb begin
		lo_c = lo_ok_s5 ? lo_rd : '0;
		hi_c = hi_ok_s5 ? hi_rd : '0;
		w_hi = {1'b0, frac_s5};
		w_lo = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - w_hi;
		for (int c = 0; c < 3; c++) begin
			if (pick_s5 == PICK_BLEND) begin
				sum_c[c] = SUMW'((SUMW+1)'(lo_c[c*8 +: 8]) * (SUMW+1)'(w_lo)
					+ (SUMW+1)'(hi_c[c*8 +: 8]) * (SUMW+1)'(w_hi));
			end else begin
				sum_c[c] = {lo_c[c*8 +: 8], {FRACTION_BITS{1'b0}}};
			end
		end
	end

	// Stage 6: weighted sums.
	logic            valid_s6;
	logic            wr_s6;
	logic            bad_s6;
	logic [AW-1:0]   band_s6;
	logic [SUMW-1:0] sum_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_s6   <= wr_s5;
			bad_s6  <= pick_s5 == PICK_BAD_SPAN;
			band_s6 <= band_s5;
			sum_s6  <= sum_c;
		end
	end

	// Output register; palette writes end here without a word.
	logic [BW-1:0] band_ext;
	assign band_ext = BW'(band_s6);

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s6 && !wr_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'd0, band_ext[3:0],
				sum_s6[0][FRACTION_BITS +: 8],
				sum_s6[1][FRACTION_BITS +: 8],
				sum_s6[2][FRACTION_BITS +: 8]};
			out_bad_q  <= bad_s6;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_bad_q;

`ifndef SYNTH
	// A mapped sample leaving the last stage must become an output word.
	a_map_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s6 && !wr_s6) |=> m_tvalid)
		else $error("mapped sample lost at output register");

	// A palette write must never produce an output word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s6 && wr_s6) |=> !m_tvalid)
		else $error("palette write produced an output word");

	// An empty span always reports entry zero.
	a_bad_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[27:24] == 4'd0))
		else $error("empty span with nonzero band index");
`endif
endmodule
